/* rtl/crc16_frame_parser_assert.svh */
// assertion macros for the crc16 frame parser
// expects clk and rst in the scope of each use
`ifndef CRC16_FRAME_PARSER_ASSERT_SVH
`define CRC16_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, off while in reset
`define CRCFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define CRCFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/crcfp_pkg.sv */
// shared types, constants and the crc byte update for the crc16 frame parser
// no dependencies
package crcfp_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  START_MARK = 8'h24;
  localparam logic [7:0]  LEN_RESET  = 8'd8;

  // positions inside a frame
  localparam logic [2:0] POS_MARK     = 3'd0;
  localparam logic [2:0] POS_LEN      = 3'd1;
  localparam logic [2:0] POS_TYPE     = 3'd2;
  localparam logic [2:0] POS_ADDR     = 3'd3;
  localparam logic [2:0] POS_PAY_HI   = 3'd4;
  localparam logic [2:0] POS_PAY_LO   = 3'd5;
  localparam logic [2:0] POS_CRC_HI   = 3'd6;
  localparam logic [2:0] POS_CRC_LO   = 3'd7;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_HDR_ERR = 2'd1,
    STATUS_CRC_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] payload;
    logic [1:0]  channel;
    logic [1:0]  device;
    logic [3:0]  room;
    logic [7:0]  msg_type;
    status_t     status;
  } result_t;

  // reflected crc-16 over one byte, bit at a time
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/crcfp_parser.sv */
// frame position tracking, running crc, field capture and result forming
// depends on crcfp_pkg
module crcfp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic              frame_start,
  output logic              res_valid,
  output crcfp_pkg::result_t res
);

  logic [7:0]  length_code;
  logic [2:0]  byte_pos;
  logic [15:0] crc_reg;
  logic        header_good;
  logic [7:0]  type_hold;
  logic [7:0]  addr_hold;
  logic [15:0] payload_hold;
  logic [7:0]  crc_high_hold;

  logic [2:0]  pos;
  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic        header_good_next;
  logic [15:0] rx_crc;

  assign pos      = frame_start ? crcfp_pkg::POS_MARK : byte_pos;
  assign crc_base = (pos == crcfp_pkg::POS_MARK) ? crcfp_pkg::CRC_INIT : crc_reg;
  // crc covers positions before the crc bytes only
  assign crc_next = (pos < crcfp_pkg::POS_CRC_HI) ?
                    crcfp_pkg::crc16_byte(crc_base, rx_byte) : crc_reg;
  assign rx_crc   = {crc_high_hold, rx_byte};

  always_comb begin
    header_good_next = header_good;
    if (pos == crcfp_pkg::POS_MARK) begin
      header_good_next = (rx_byte == crcfp_pkg::START_MARK);
    end else if (pos == crcfp_pkg::POS_LEN) begin
      header_good_next = header_good & (rx_byte == length_code);
    end
  end

  always_comb begin
    res_valid = accept && (pos == crcfp_pkg::POS_CRC_LO);
    if (!header_good) begin
      res          = '0;
      res.status   = crcfp_pkg::STATUS_HDR_ERR;
    end else begin
      res.status   = (rx_crc == crc_reg) ? crcfp_pkg::STATUS_OK : crcfp_pkg::STATUS_CRC_ERR;
      res.msg_type = type_hold;
      res.room     = addr_hold[7:4];
      res.device   = addr_hold[3:2];
      res.channel  = addr_hold[1:0];
      res.payload  = payload_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_code <= crcfp_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      length_code <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos      <= crcfp_pkg::POS_MARK;
      crc_reg       <= crcfp_pkg::CRC_INIT;
      header_good   <= 1'b1;
      type_hold     <= '0;
      addr_hold     <= '0;
      payload_hold  <= '0;
      crc_high_hold <= '0;
    end else if (accept) begin
      byte_pos    <= pos + 3'd1;
      crc_reg     <= crc_next;
      header_good <= header_good_next;
      unique case (pos)
        crcfp_pkg::POS_TYPE:   type_hold          <= rx_byte;
        crcfp_pkg::POS_ADDR:   addr_hold          <= rx_byte;
        crcfp_pkg::POS_PAY_HI: payload_hold[15:8] <= rx_byte;
        crcfp_pkg::POS_PAY_LO: payload_hold[7:0]  <= rx_byte;
        crcfp_pkg::POS_CRC_HI: crc_high_hold      <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/crcfp_out_skid.sv */
// two-entry result buffer: output register plus skid register
// depends on crcfp_pkg
module crcfp_out_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  crcfp_pkg::result_t push_data,
  output logic               can_accept,
  output logic               out_valid,
  input  logic               out_ready,
  output crcfp_pkg::result_t out_data
);

  logic               skid_valid;
  crcfp_pkg::result_t skid_data;
  logic               pop;

  assign pop        = out_valid && out_ready;
  // the skid slot must be free before another input beat can be taken
  assign can_accept = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

/* rtl/crc16_frame_parser.sv */
// crc16 frame parser top level: stream ports, parser and result buffer
// depends on crcfp_pkg, crcfp_parser, crcfp_out_skid, crc16_frame_parser_assert.svh
//
// Checks 8-byte frames received one byte per input beat ('$', length byte, type,
// address, payload high, payload low, crc high, crc low) and delivers one result
// beat after the last byte. The position, running crc-16 and captured fields update
// at the edge that accepts the byte; the result of the last byte is loaded at that
// edge into the output register, offered from the next cycle, or into the skid
// register while the output register stays full. A byte can be accepted every
// cycle; input stalls only when both registers are full. tuser high on an input
// beat forces it to be byte 0 of a new frame. length_code resets to 8; the user
// writes it by cfg_wr_en/cfg_wr_data only while idle, not enforced by the block.
module crc16_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic        s_axis_tuser,  // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [1:0] status, [9:2] msg_type, [13:10] room,
                                     // [15:14] device, [17:16] channel, [33:18] payload
);

  logic               accept;
  logic               res_valid;
  crcfp_pkg::result_t res;
  crcfp_pkg::result_t out_res;
  logic               out_hdr_err;
  logic               push_blocked;

  assign accept = s_axis_tvalid && s_axis_tready;

  crcfp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .rx_byte     (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .res_valid   (res_valid),
    .res         (res)
  );

  crcfp_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_res)
  );

  assign m_axis_tdata = {6'b0, out_res.payload, out_res.channel, out_res.device,
                         out_res.room, out_res.msg_type, out_res.status};

  assign out_hdr_err  = m_axis_tvalid && (out_res.status == crcfp_pkg::STATUS_HDR_ERR);
  assign push_blocked = res_valid && m_axis_tvalid && !m_axis_tready;

`include "crc16_frame_parser_assert.svh"

  `CRCFP_ASSERT_NOW(a_push_needs_beat, res_valid, accept, "result without input beat")
  `CRCFP_ASSERT_NOW(a_stall_means_full, !s_axis_tready, m_axis_tvalid, "skid full with output empty")
  `CRCFP_ASSERT_NOW(a_hdr_err_zero, out_hdr_err, m_axis_tdata[39:2] == '0, "header error with fields")
  `CRCFP_ASSERT_NEXT(a_skid_fills, push_blocked, !s_axis_tready, "stalled result lost")

endmodule

/* test/crc16_frame_parser_checker.sv */
// scoreboard for the crc16 frame parser: watches config, byte and result channels,
// predicts each frame result and compares it field by field
// depends on crcfp_pkg; also holds crcfp_tb_pkg, the crc helper shared with tb
package crcfp_tb_pkg;

  import crcfp_pkg::*;

  // modbus crc-16, lsb first, one byte
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

module crc16_frame_parser_checker
  import crcfp_pkg::*;
  import crcfp_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic        s_axis_tuser,  // [0] frame_start
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,  // [1:0] status, [9:2] msg_type, [13:10] room,
                                     // [15:14] device, [17:16] channel, [33:18] payload
  output int          mismatches,
  output int          pending,
  output int          checked
);

  logic [7:0]  len_code;
  logic [2:0]  pos;
  logic [15:0] run_crc;
  logic        hdr_ok;
  logic [7:0]  type_byte;
  logic [7:0]  addr_byte;
  logic [15:0] pay_word;
  logic [7:0]  crc_hi;
  result_t     frame_results [$];
  int          errs;
  int          n_checked;

  task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
    errs++;
    if (errs <= 10) begin
      $display("mismatch at %0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  // advance the frame state by one byte, queue a result after the last crc byte
  task automatic take_byte(input logic [7:0] b, input logic start);
    logic [2:0] p;
    result_t    r;
    p = start ? POS_MARK : pos;
    if (p == POS_MARK) begin
      run_crc = CRC_INIT;
      hdr_ok  = (b == START_MARK);
    end
    if (p < POS_CRC_HI) begin
      run_crc = crc16_next(run_crc, b);
    end
    case (p)
      POS_LEN: begin
        if (b != len_code) begin
          hdr_ok = 1'b0;
        end
      end
      POS_TYPE:   type_byte = b;
      POS_ADDR:   addr_byte = b;
      POS_PAY_HI: pay_word[15:8] = b;
      POS_PAY_LO: pay_word[7:0] = b;
      POS_CRC_HI: crc_hi = b;
      POS_CRC_LO: begin
        r = '0;
        if (!hdr_ok) begin
          r.status = STATUS_HDR_ERR;
        end else begin
          // crc travels high byte first
          r.status   = ({crc_hi, b} == run_crc) ? STATUS_OK : STATUS_CRC_ERR;
          r.msg_type = type_byte;
          r.room     = addr_byte[7:4];
          r.device   = addr_byte[3:2];
          r.channel  = addr_byte[1:0];
          r.payload  = pay_word;
        end
        frame_results.push_back(r);
      end
      default: ;
    endcase
    pos = p + 3'd1;
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      len_code  = LEN_RESET;
      pos       = POS_MARK;
      run_crc   = CRC_INIT;
      hdr_ok    = 1'b1;
      type_byte = '0;
      addr_byte = '0;
      pay_word  = '0;
      crc_hi    = '0;
      frame_results.delete();
      errs      = 0;
      n_checked = 0;
    end else begin
      if (cfg_wr_en) begin
        len_code = cfg_wr_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[33:0]);
        if (frame_results.size() == 0) begin
          flag("result beat with nothing pending", '0, got);
        end else begin
          want = frame_results.pop_front();
          n_checked++;
          if (got.status != want.status) flag("status", want.status, got.status);
          if (got.msg_type != want.msg_type) flag("msg_type", want.msg_type, got.msg_type);
          if (got.room != want.room) flag("room", want.room, got.room);
          if (got.device != want.device) flag("device", want.device, got.device);
          if (got.channel != want.channel) flag("channel", want.channel, got.channel);
          if (got.payload != want.payload) flag("payload", want.payload, got.payload);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_byte(s_axis_tdata, s_axis_tuser);
      end
    end
    mismatches <= errs;
    pending    <= frame_results.size();
    checked    <= n_checked;
  end

endmodule

/* test/tb.sv */
// top of the crc16 frame parser testbench: clock, reset, byte stimulus, result stalls
// and the verdict; depends on crcfp_pkg, crcfp_tb_pkg and crc16_frame_parser_checker
module tb;

  import crcfp_pkg::*;
  import crcfp_tb_pkg::*;

  typedef enum int {
    FRM_GOOD,
    FRM_BAD_CRC,
    FRM_BAD_MARK,
    FRM_BAD_LEN,
    FRM_CUT,
    FRM_NOISE
  } frame_kind_t;

  localparam int LIMIT       = 200000;
  localparam int PHASE_BYTES = 195;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_wr_en     = 1'b0;
  logic [7:0]  cfg_wr_data   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  logic        quiet   = 1'b0;
  logic        aligned = 1'b1;
  int          cycles  = 0;
  int          bytes_sent = 0;
  int          mismatches;
  int          pending;
  int          checked;

  crc16_frame_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  crc16_frame_parser_checker frame_chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .checked      (checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    while (!quiet && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // wait until every queued frame result has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_length(input logic [7:0] code);
    drain();
    // a cut frame leaves no result behind for drain to wait on, so pause before the write
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_frame(input frame_kind_t kind, input logic [7:0] len,
                            input logic [31:0] body, input logic start, input int count);
    logic [7:0]  fb [8];
    logic [15:0] crc;
    fb[0] = START_MARK;
    fb[1] = len;
    fb[2] = body[31:24];
    fb[3] = body[23:16];
    fb[4] = body[15:8];
    fb[5] = body[7:0];
    if (kind == FRM_BAD_MARK) fb[0] = START_MARK ^ 8'($urandom_range(1, 255));
    if (kind == FRM_BAD_LEN) fb[1] = len ^ 8'($urandom_range(1, 255));
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc16_next(crc, fb[i]);
    end
    fb[6] = crc[15:8];
    fb[7] = crc[7:0];
    if (kind == FRM_BAD_CRC) fb[6 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
    if (kind == FRM_NOISE) begin
      for (int i = 0; i < count; i++) begin
        send_byte(8'($urandom), $urandom_range(3) == 0);
      end
      aligned = 1'b0;
    end else begin
      // without a start flag the byte only lands at position 0 after a whole frame
      for (int i = 0; i < count; i++) begin
        send_byte(fb[i], (i == 0) && (start || !aligned));
      end
      aligned = (count == 8);
    end
  endtask

  task automatic random_frame(input logic [7:0] len);
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_frame(FRM_GOOD, len, $urandom, $urandom_range(1), 8);
    end else if (pick < 70) begin
      send_frame(FRM_BAD_CRC, len, $urandom, $urandom_range(1), 8);
    end else if (pick < 78) begin
      send_frame(FRM_BAD_MARK, len, $urandom, $urandom_range(1), 8);
    end else if (pick < 86) begin
      send_frame(FRM_BAD_LEN, len, $urandom, $urandom_range(1), 8);
    end else if (pick < 93) begin
      send_frame(FRM_CUT, len, $urandom, 1'b1, $urandom_range(1, 7));
    end else begin
      send_frame(FRM_NOISE, len, $urandom, 1'b0, $urandom_range(1, 12));
    end
  endtask

  initial begin
    logic [7:0] codes [4];
    int         start_bytes;
    codes = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), LEN_RESET};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // abandoned frame, then all-ones fields, wrapped crc error, bad length byte
    send_frame(FRM_CUT, LEN_RESET, 32'h0, 1'b1, 3);
    send_frame(FRM_GOOD, LEN_RESET, 32'hFFFF_FFFF, 1'b1, 8);
    send_frame(FRM_BAD_CRC, LEN_RESET, 32'h0, 1'b0, 8);
    send_frame(FRM_BAD_LEN, LEN_RESET, $urandom, 1'b0, 8);

    for (int ph = 0; ph < 4; ph++) begin
      write_length(codes[ph]);
      quiet <= (ph == 2);
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < PHASE_BYTES) begin
        random_frame(codes[ph]);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("sent %0d bytes under the reset length code and four written ones", bytes_sent);
    $display("compared %0d frame results field by field", checked);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
